>>> src/sedt_pkg.sv
// ----------------------------------------------------------------------------
// sedt_pkg
// Shared types and constants for the switch event debounce and throttle block.
// ----------------------------------------------------------------------------
package sedt_pkg;

    localparam int DEFAULT_SWITCH_COUNT = 320;

    localparam int SWITCH_W   = 9;
    localparam int TIME_W     = 32;
    localparam int MS_REG_W   = 16;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [1:0] {
        PH_IDLE        = 2'd0,
        PH_WAIT_ACTIVE = 2'd1,
        PH_ACTIVE      = 2'd2,
        PH_WAIT_IDLE   = 2'd3
    } t_phase;

    typedef enum logic [KIND_W-1:0] {
        EV_NONE    = 2'd0,
        EV_PRESS   = 2'd1,
        EV_RELEASE = 2'd2
    } t_ev_kind;

    typedef enum logic [KIND_W-1:0] {
        SUB_NONE = 2'd0,
        SUB_ON   = 2'd1,
        SUB_OFF  = 2'd2
    } t_sub;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PRESS_HOLD_US   = 2'd0,
        REG_RELEASE_HOLD_US = 2'd1,
        REG_THROTTLE_MS     = 2'd2,
        REG_SEPARATION_MS   = 2'd3
    } t_reg_idx;

    typedef struct packed {
        t_phase              phase;
        logic [TIME_W-1:0]   db_started;
        logic                thr_blocking;
        logic [TIME_W-1:0]   thr_started;
    } t_rec;

endpackage

>>> src/sedt_ifs.sv
// ----------------------------------------------------------------------------
// sedt_ifs
// Valid/ready channels: raw switch events, filtered results, register writes.
// ----------------------------------------------------------------------------
interface sedt_in_if;
    import sedt_pkg::*;

    logic                valid;
    logic                ready;
    logic [SWITCH_W-1:0] switch_number;
    logic                is_press;
    logic [TIME_W-1:0]   now_us;
    logic [TIME_W-1:0]   now_ms;

    modport source (output valid, switch_number, is_press, now_us, now_ms, input ready);
    modport sink   (input valid, switch_number, is_press, now_us, now_ms, output ready);
endinterface

interface sedt_out_if;
    import sedt_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   event_kind;
    logic [SWITCH_W-1:0] event_switch;
    logic [KIND_W-1:0]   subscription;

    modport source (output valid, event_kind, event_switch, subscription, input ready);
    modport sink   (input valid, event_kind, event_switch, subscription, output ready);
endinterface

interface sedt_cfg_if;
    import sedt_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> src/switch_event_debounce_throttle_top.sv
// Throughput: one event word per cycle while o_res.ready is high and no clearing
//   sweep runs; the per-switch record is read in the accept cycle, then modified
//   and written back as the word moves to the output register, with forwarding.
// Reset: configuration registers, valid flags and the last-press time clear to
//   zero; a clearing sweep then writes SWITCH_COUNT records, one per cycle,
//   while event words are held off (register writes accepted).
// ----------------------------------------------------------------------------
// switch_event_debounce_throttle_top
// Debounce, per-switch press throttle and global press separation filter.
// ----------------------------------------------------------------------------
module switch_event_debounce_throttle_top #(
    parameter int SWITCH_COUNT = sedt_pkg::DEFAULT_SWITCH_COUNT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sedt_in_if.sink   i_evt,
    sedt_cfg_if.sink  i_cfg,
    sedt_out_if.source o_res
);
    import sedt_pkg::*;

    localparam int IDX_W    = (SWITCH_COUNT > 1) ? $clog2(SWITCH_COUNT) : 1;
    localparam int CNT_W    = $clog2(SWITCH_COUNT + 1);
    localparam int SW_EXT_W = (CNT_W > SWITCH_W) ? CNT_W : SWITCH_W;

    logic [TIME_W-1:0]   r_press_hold_us;
    logic [TIME_W-1:0]   r_release_hold_us;
    logic [MS_REG_W-1:0] r_throttle_ms;
    logic [MS_REG_W-1:0] r_separation_ms;
    logic [TIME_W-1:0]   r_last_press;

    logic                r_s1_valid;
    logic                r_s1_hit;
    logic [IDX_W-1:0]    r_s1_idx;
    logic [SWITCH_W-1:0] r_s1_sw;
    logic                r_s1_press;
    logic [TIME_W-1:0]   r_s1_us;
    logic [TIME_W-1:0]   r_s1_ms;

    logic                r_out_valid;
    t_ev_kind            r_out_kind;
    logic [SWITCH_W-1:0] r_out_switch;
    t_sub                r_out_sub;

    logic                clearing;
    logic                in_fire;
    logic                s1_fire;
    logic [SW_EXT_W-1:0] sw_ext;
    logic                in_hit;
    logic [IDX_W-1:0]    in_idx;

    t_rec                rec;
    t_rec                n_rec;
    t_ev_kind            n_kind;
    t_sub                n_sub;
    logic                n_sep_take;
    logic [TIME_W-1:0]   db_elapsed;
    logic [TIME_W-1:0]   thr_elapsed;
    logic [TIME_W-1:0]   sep_elapsed;
    logic                thr_expired;

    // configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_hold_us   <= '0;
            r_release_hold_us <= '0;
            r_throttle_ms     <= '0;
            r_separation_ms   <= '0;
        end else if (i_cfg.valid) begin
            case (t_reg_idx'(i_cfg.index))
                REG_PRESS_HOLD_US:   r_press_hold_us   <= i_cfg.data[TIME_W-1:0];
                REG_RELEASE_HOLD_US: r_release_hold_us <= i_cfg.data[TIME_W-1:0];
                REG_THROTTLE_MS:     r_throttle_ms     <= i_cfg.data[MS_REG_W-1:0];
                REG_SEPARATION_MS:   r_separation_ms   <= i_cfg.data[MS_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // accept and index
    assign sw_ext  = SW_EXT_W'(i_evt.switch_number);
    assign in_hit  = (sw_ext != '0) && (sw_ext <= SW_EXT_W'(SWITCH_COUNT));
    assign in_idx  = in_hit ? IDX_W'(sw_ext - 1'b1) : '0;

    assign s1_fire     = r_s1_valid && (!r_out_valid || o_res.ready);
    assign i_evt.ready = !clearing && (!r_s1_valid || s1_fire);
    assign in_fire     = i_evt.valid && i_evt.ready;

    sedt_rec_store #(
        .SWITCH_COUNT (SWITCH_COUNT)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (in_fire),
        .i_rd_idx   (in_idx),
        .o_rd_data  (rec),
        .i_wr_en    (s1_fire && r_s1_hit),
        .i_wr_idx   (r_s1_idx),
        .i_wr_data  (n_rec),
        .o_clearing (clearing)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
        if (in_fire) begin
            r_s1_hit   <= in_hit;
            r_s1_idx   <= in_idx;
            r_s1_sw    <= i_evt.switch_number;
            r_s1_press <= i_evt.is_press;
            r_s1_us    <= i_evt.now_us;
            r_s1_ms    <= i_evt.now_ms;
        end
    end

    // modify
    assign db_elapsed  = r_s1_us - rec.db_started;
    assign thr_elapsed = r_s1_ms - rec.thr_started;
    assign sep_elapsed = r_s1_ms - r_last_press;
    assign thr_expired = thr_elapsed >= TIME_W'(r_throttle_ms);

    always_comb begin
        n_rec      = rec;
        n_kind     = EV_NONE;
        n_sub      = SUB_NONE;
        n_sep_take = 1'b0;

        case (rec.phase)
            PH_IDLE: begin
                if (r_s1_press) begin
                    n_rec.db_started = r_s1_us;
                    n_sub            = SUB_ON;
                    if (r_press_hold_us == '0) begin
                        n_rec.phase = PH_ACTIVE;
                        n_kind      = EV_PRESS;
                    end else begin
                        n_rec.phase = PH_WAIT_ACTIVE;
                    end
                end
            end
            PH_WAIT_ACTIVE: begin
                if (db_elapsed >= r_press_hold_us) begin
                    n_kind = EV_PRESS;
                    if (r_release_hold_us == '0) begin
                        n_rec.phase = PH_WAIT_IDLE;
                        n_sub       = SUB_OFF;
                    end else begin
                        n_rec.phase      = PH_ACTIVE;
                        n_rec.db_started = r_s1_us;
                        n_sub            = SUB_ON;
                    end
                end else if (!r_s1_press) begin
                    n_rec.phase = PH_IDLE;
                    n_sub       = SUB_OFF;
                end
            end
            PH_ACTIVE: begin
                if (db_elapsed >= r_release_hold_us) begin
                    n_sub = SUB_OFF;
                    if (r_s1_press) begin
                        n_rec.phase = PH_WAIT_IDLE;
                    end else begin
                        n_rec.phase = PH_IDLE;
                        n_kind      = EV_RELEASE;
                    end
                end
            end
            default: begin
                if (!r_s1_press) begin
                    n_rec.phase = PH_IDLE;
                    n_kind      = EV_RELEASE;
                end
            end
        endcase

        if (n_kind != EV_NONE) begin
            if (!rec.thr_blocking) begin
                if (n_kind == EV_PRESS && r_throttle_ms != '0) begin
                    n_rec.thr_started  = r_s1_ms;
                    n_rec.thr_blocking = 1'b1;
                end
            end else if (n_kind == EV_PRESS) begin
                if (thr_expired) begin
                    n_rec.thr_started = r_s1_ms;
                end else begin
                    n_kind = EV_NONE;
                end
            end else if (thr_expired) begin
                n_rec.thr_blocking = 1'b0;
            end
        end

        if (n_kind == EV_PRESS) begin
            if (r_separation_ms != '0 && sep_elapsed < TIME_W'(r_separation_ms)) begin
                n_kind = EV_NONE;
            end else begin
                n_sep_take = 1'b1;
            end
        end

        if (!r_s1_hit) begin
            n_kind     = EV_NONE;
            n_sub      = SUB_NONE;
            n_sep_take = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_press <= '0;
        end else if (s1_fire && n_sep_take) begin
            r_last_press <= r_s1_ms;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
        if (s1_fire) begin
            r_out_kind   <= n_kind;
            r_out_switch <= (n_kind != EV_NONE) ? r_s1_sw : '0;
            r_out_sub    <= n_sub;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.event_kind   = r_out_kind;
    assign o_res.event_switch = r_out_switch;
    assign o_res.subscription = r_out_sub;

endmodule

>>> src/sedt_rec_store.sv
// ----------------------------------------------------------------------------
// sedt_rec_store
// Per-switch record memory: registered read, write-back forwarding,
// and a clearing sweep after reset.
// ----------------------------------------------------------------------------
module sedt_rec_store #(
    parameter int SWITCH_COUNT = sedt_pkg::DEFAULT_SWITCH_COUNT,
    localparam int IDX_W = (SWITCH_COUNT > 1) ? $clog2(SWITCH_COUNT) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_idx,
    output sedt_pkg::t_rec   o_rd_data,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_idx,
    input  sedt_pkg::t_rec   i_wr_data,
    output logic             o_clearing
);
    import sedt_pkg::*;

    t_rec             mem [SWITCH_COUNT];
    t_rec             r_rd_q;
    logic [IDX_W-1:0] r_rd_idx;

    logic             r_clearing;
    logic [IDX_W-1:0] r_clr_idx;

    logic             r_fwd_valid;
    logic [IDX_W-1:0] r_fwd_idx;
    t_rec             r_fwd_data;

    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    t_rec             wr_data;

    always_comb begin
        wr_en   = r_clearing | i_wr_en;
        wr_idx  = r_clearing ? r_clr_idx : i_wr_idx;
        wr_data = r_clearing ? t_rec'('0) : i_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
        if (i_rd_en) begin
            r_rd_q   <= mem[i_rd_idx];
            r_rd_idx <= i_rd_idx;
        end
    end

    // hold the most recent write; it is the newest value for its entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else if (wr_en) begin
            r_fwd_valid <= 1'b1;
        end
        if (wr_en) begin
            r_fwd_idx  <= wr_idx;
            r_fwd_data <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            if (r_clr_idx == IDX_W'(SWITCH_COUNT - 1)) begin
                r_clearing <= 1'b0;
            end else begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
        end
    end

    assign o_rd_data  = (r_fwd_valid && r_fwd_idx == r_rd_idx) ? r_fwd_data : r_rd_q;
    assign o_clearing = r_clearing;

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the switch event filter. A directed table covers
// reset behavior, ignored switch numbers, hold expiry, throttle and separation
// drops and register extremes. Random phases under several register settings
// then follow. Every result word is checked against its typed table entry or
// an in-bench model of the debounce, throttle and separation stages.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sedt_pkg::*;

    localparam int N_SW       = DEFAULT_SWITCH_COUNT;
    localparam int CYCLE_CAP  = 200000;
    localparam int RAND_PHASE = 125;

    typedef struct packed {
        t_ev_kind            kind;
        logic [SWITCH_W-1:0] sw;
        t_sub                sub;
    } t_filtered;

    typedef struct packed {
        bit                  is_cfg;
        t_reg_idx            idx;
        logic [31:0]         wdata;
        logic [SWITCH_W-1:0] sw;
        bit                  press;
        logic [31:0]         us;
        logic [31:0]         ms;
        bit                  typed;
        t_filtered           res;
    } t_script_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    sedt_in_if  evt_if ();
    sedt_cfg_if cfg_if ();
    sedt_out_if res_if ();

    switch_event_debounce_throttle_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // filter state
    logic [31:0]       hold_press_us = '0;
    logic [31:0]       hold_release_us = '0;
    logic [15:0]       throttle_gap_ms = '0;
    logic [15:0]       separation_gap_ms = '0;
    t_phase            db_phase [N_SW];
    logic [31:0]       db_since [N_SW];
    bit                thr_blocking [N_SW];
    logic [31:0]       thr_since [N_SW];
    logic [31:0]       last_press_ms = '0;

    t_filtered         pending_results [$];
    t_filtered         oldest;
    t_script_row       script [$];
    int                mismatches = 0;
    int                result_count = 0;
    int                cycles = 0;
    bit                quiet = 1'b0;
    bit                pressure_done = 1'b0;
    bit                last_sign [512];
    logic [31:0]       run_us;
    logic [31:0]       run_ms;
    int                us_span;
    int                ms_span;

    function automatic t_filtered filter_event(logic [SWITCH_W-1:0] sw, bit press,
                                               logic [31:0] us, logic [31:0] ms);
        t_filtered   r;
        int          i;
        logic [31:0] elapsed;
        logic [31:0] gap;
        t_ev_kind    ev;
        r = '{kind: EV_NONE, sw: '0, sub: SUB_NONE};
        ev = EV_NONE;
        if (sw == 0 || sw > N_SW) return r;
        i = int'(sw) - 1;
        elapsed = us - db_since[i];
        case (db_phase[i])
            PH_IDLE: begin
                if (press) begin
                    db_since[i] = us;
                    r.sub = SUB_ON;
                    if (hold_press_us == 0) begin
                        db_phase[i] = PH_ACTIVE;
                        ev = EV_PRESS;
                    end else begin
                        db_phase[i] = PH_WAIT_ACTIVE;
                    end
                end
            end
            PH_WAIT_ACTIVE: begin
                if (elapsed >= hold_press_us) begin
                    if (hold_release_us == 0) begin
                        db_phase[i] = PH_WAIT_IDLE;
                        r.sub = SUB_OFF;
                    end else begin
                        db_phase[i] = PH_ACTIVE;
                        db_since[i] = us;
                        r.sub = SUB_ON;
                    end
                    ev = EV_PRESS;
                end else if (!press) begin
                    db_phase[i] = PH_IDLE;
                    r.sub = SUB_OFF;
                end
            end
            PH_ACTIVE: begin
                if (elapsed >= hold_release_us) begin
                    r.sub = SUB_OFF;
                    if (press) begin
                        db_phase[i] = PH_WAIT_IDLE;
                    end else begin
                        db_phase[i] = PH_IDLE;
                        ev = EV_RELEASE;
                    end
                end
            end
            default: begin
                if (!press) begin
                    db_phase[i] = PH_IDLE;
                    ev = EV_RELEASE;
                end
            end
        endcase
        if (ev != EV_NONE) begin
            if (!thr_blocking[i]) begin
                if (ev == EV_PRESS && throttle_gap_ms != 0) begin
                    thr_since[i] = ms;
                    thr_blocking[i] = 1'b1;
                end
            end else begin
                gap = ms - thr_since[i];
                if (ev == EV_PRESS) begin
                    if (gap >= {16'd0, throttle_gap_ms}) thr_since[i] = ms;
                    else ev = EV_NONE;
                end else if (gap >= {16'd0, throttle_gap_ms}) begin
                    thr_blocking[i] = 1'b0;
                end
            end
        end
        if (ev == EV_PRESS) begin
            gap = ms - last_press_ms;
            if (separation_gap_ms != 0 && gap < {16'd0, separation_gap_ms}) ev = EV_NONE;
            else last_press_ms = ms;
        end
        r.kind = ev;
        r.sw = (ev != EV_NONE) ? sw : '0;
        return r;
    endfunction

    function automatic t_script_row ev_row(logic [SWITCH_W-1:0] sw, bit press,
                                           logic [31:0] us, logic [31:0] ms);
        t_script_row r;
        r = '0;
        r.idx = REG_PRESS_HOLD_US;
        r.res = '{kind: EV_NONE, sw: '0, sub: SUB_NONE};
        r.sw = sw;
        r.press = press;
        r.us = us;
        r.ms = ms;
        return r;
    endfunction

    function automatic t_script_row chk_row(logic [SWITCH_W-1:0] sw, bit press,
                                            logic [31:0] us, logic [31:0] ms,
                                            t_ev_kind kind, logic [SWITCH_W-1:0] esw,
                                            t_sub sub);
        t_script_row r;
        r = ev_row(sw, press, us, ms);
        r.typed = 1'b1;
        r.res = '{kind: kind, sw: esw, sub: sub};
        return r;
    endfunction

    function automatic t_script_row cfg_row(t_reg_idx idx, logic [31:0] wdata);
        t_script_row r;
        r = ev_row('0, 1'b0, '0, '0);
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.wdata = wdata;
        return r;
    endfunction

    task automatic note_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10) $display("mismatch at cycle %0d: %s", cycles, msg);
    endtask

    task automatic send_event(logic [SWITCH_W-1:0] sw, bit press, logic [31:0] us,
                              logic [31:0] ms, bit typed, t_filtered want);
        t_filtered got;
        @(negedge i_clk);
        evt_if.valid = 1'b1;
        evt_if.switch_number = sw;
        evt_if.is_press = press;
        evt_if.now_us = us;
        evt_if.now_ms = ms;
        do begin
            @(posedge i_clk);
        end while (!evt_if.ready);
        got = filter_event(sw, press, us, ms);
        if (typed) got = want;
        pending_results.push_back(got);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [31:0] wdata);
        @(negedge i_clk);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data = wdata;
        do begin
            @(posedge i_clk);
        end while (!cfg_if.ready);
        case (idx)
            REG_PRESS_HOLD_US:   hold_press_us = wdata;
            REG_RELEASE_HOLD_US: hold_release_us = wdata;
            REG_THROTTLE_MS:     throttle_gap_ms = wdata[15:0];
            default:             separation_gap_ms = wdata[15:0];
        endcase
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic drain();
        @(negedge i_clk);
        evt_if.valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic maybe_idle();
        if (!quiet && $urandom_range(0, 5) == 0) begin
            @(negedge i_clk);
            evt_if.valid = 1'b0;
            repeat ($urandom_range(0, 15)) @(negedge i_clk);
        end
    endtask

    task automatic random_event();
        logic [SWITCH_W-1:0] sw;
        bit                  press;
        logic [31:0]         us;
        logic [31:0]         ms;
        int                  k;
        run_us += $urandom_range(0, us_span);
        run_ms += $urandom_range(0, ms_span);
        us = run_us;
        ms = run_ms;
        if ($urandom_range(0, 9) == 0) begin
            sw = SWITCH_W'($urandom_range(0, 511));
            press = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 1) == 0) begin
                us = $urandom;
                ms = $urandom;
            end
        end else begin
            k = $urandom_range(0, 6);
            sw = (k == 6) ? SWITCH_W'(N_SW) : SWITCH_W'(k + 1);
            press = ($urandom_range(0, 9) < 6) ? !last_sign[sw] : last_sign[sw];
            last_sign[sw] = press;
        end
        send_event(sw, press, us, ms, 1'b0, '0);
    endtask

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_CAP) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            result_count++;
            if (pending_results.size() == 0) begin
                note_mismatch($sformatf("unexpected word kind=%0d sw=%0d sub=%0d",
                    res_if.event_kind, res_if.event_switch, res_if.subscription));
            end else begin
                oldest = pending_results.pop_front();
                if (res_if.event_kind !== oldest.kind || res_if.event_switch !== oldest.sw
                        || res_if.subscription !== oldest.sub)
                    note_mismatch($sformatf("exp kind=%0d sw=%0d sub=%0d got %0d %0d %0d",
                        oldest.kind, oldest.sw, oldest.sub, res_if.event_kind,
                        res_if.event_switch, res_if.subscription));
            end
        end
    end

    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!quiet && !pressure_done && result_count >= 40) begin
                res_if.ready = 1'b0;
                repeat (299) @(negedge i_clk);
                pressure_done = 1'b1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                res_if.ready = 1'b0;
                repeat ($urandom_range(0, 15)) @(negedge i_clk);
            end else begin
                res_if.ready = 1'b1;
            end
        end
    end

    initial begin
        evt_if.valid = 1'b0;
        evt_if.switch_number = '0;
        evt_if.is_press = 1'b0;
        evt_if.now_us = '0;
        evt_if.now_ms = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = REG_PRESS_HOLD_US;
        cfg_if.data = '0;
        foreach (db_phase[i]) begin
            db_phase[i] = PH_IDLE;
            db_since[i] = '0;
            thr_blocking[i] = 1'b0;
            thr_since[i] = '0;
        end
        foreach (last_sign[i]) last_sign[i] = 1'b0;

        script.push_back(chk_row(0, 1, 0, 0, EV_NONE, 0, SUB_NONE));
        script.push_back(chk_row(321, 1, 5, 5, EV_NONE, 0, SUB_NONE));
        script.push_back(chk_row(511, 0, 7, 7, EV_NONE, 0, SUB_NONE));
        script.push_back(chk_row(1, 1, 100, 100, EV_PRESS, 1, SUB_ON));
        script.push_back(chk_row(1, 0, 101, 101, EV_RELEASE, 1, SUB_OFF));
        script.push_back(chk_row(320, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, EV_PRESS, 320, SUB_ON));
        script.push_back(ev_row(320, 1, 0, 0));
        script.push_back(ev_row(320, 0, 1, 1));
        script.push_back(cfg_row(REG_PRESS_HOLD_US, 100));
        script.push_back(cfg_row(REG_RELEASE_HOLD_US, 50));
        script.push_back(cfg_row(REG_THROTTLE_MS, 10));
        script.push_back(cfg_row(REG_SEPARATION_MS, 5));
        script.push_back(ev_row(2, 1, 1000, 1000));
        script.push_back(ev_row(2, 1, 1050, 1001));
        script.push_back(ev_row(2, 0, 1060, 1002));
        script.push_back(ev_row(2, 1, 2000, 2000));
        script.push_back(ev_row(2, 0, 2100, 2001));
        script.push_back(ev_row(2, 0, 2200, 2003));
        script.push_back(ev_row(2, 1, 3000, 2005));
        script.push_back(ev_row(2, 1, 3100, 2006));
        script.push_back(ev_row(3, 1, 4000, 2003));
        script.push_back(ev_row(3, 1, 4100, 2004));
        script.push_back(cfg_row(REG_PRESS_HOLD_US, 32'hFFFF_FFFF));
        script.push_back(cfg_row(REG_RELEASE_HOLD_US, 32'hFFFF_FFFF));
        script.push_back(cfg_row(REG_THROTTLE_MS, 32'h0000_FFFF));
        script.push_back(cfg_row(REG_SEPARATION_MS, 32'h0000_FFFF));
        script.push_back(ev_row(4, 1, 0, 0));
        script.push_back(ev_row(4, 0, 32'hFFFF_FFFF, 5));
        script.push_back(ev_row(4, 0, 10, 6));
        script.push_back(ev_row(4, 1, 20, 32'h0001_0004));

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (script[n]) begin
            if (script[n].is_cfg) begin
                if (n == 0 || !script[n-1].is_cfg) drain();
                write_reg(script[n].idx, script[n].wdata);
            end else begin
                maybe_idle();
                send_event(script[n].sw, script[n].press, script[n].us, script[n].ms,
                           script[n].typed, script[n].res);
            end
        end

        for (int ph = 0; ph < 4; ph++) begin
            drain();
            case (ph)
                0: begin
                    write_reg(REG_PRESS_HOLD_US, 20);
                    write_reg(REG_RELEASE_HOLD_US, 30);
                    write_reg(REG_THROTTLE_MS, 5);
                    write_reg(REG_SEPARATION_MS, 2);
                    us_span = 50;
                    ms_span = 4;
                end
                1: begin
                    write_reg(REG_PRESS_HOLD_US, 0);
                    write_reg(REG_RELEASE_HOLD_US, 0);
                    write_reg(REG_THROTTLE_MS, 0);
                    write_reg(REG_SEPARATION_MS, 0);
                    us_span = 10;
                    ms_span = 3;
                end
                2: begin
                    write_reg(REG_PRESS_HOLD_US, $urandom_range(0, 300));
                    write_reg(REG_RELEASE_HOLD_US, $urandom_range(0, 300));
                    write_reg(REG_THROTTLE_MS, {16'($urandom), 16'($urandom_range(0, 20))});
                    write_reg(REG_SEPARATION_MS, {16'($urandom), 16'($urandom_range(0, 6))});
                    us_span = 400;
                    ms_span = 10;
                end
                default: begin
                    write_reg(REG_PRESS_HOLD_US, 0);
                    write_reg(REG_RELEASE_HOLD_US, 32'hFFFF_FFFF);
                    write_reg(REG_THROTTLE_MS, 32'hFFFF_FFFF);
                    write_reg(REG_SEPARATION_MS, 0);
                    us_span = 100;
                    ms_span = 5;
                    quiet = 1'b1;
                end
            endcase
            run_us = $urandom;
            run_ms = $urandom;
            repeat (RAND_PHASE) begin
                maybe_idle();
                random_event();
            end
        end

        @(negedge i_clk);
        evt_if.valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
